>>> rtl/sbfd_pkg.sv
package sbfd_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;

  localparam logic [7:0] FIRST_SYNC_RESET  = 8'd36;
  localparam logic [7:0] SECOND_SYNC_RESET = 8'd64;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] HEADER_LEN = 16'd8;

  typedef enum logic [3:0] {
    PH_SYNC1  = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_CRC_LO = 4'd2,
    PH_CRC_HI = 4'd3,
    PH_ID_LO  = 4'd4,
    PH_ID_HI  = 4'd5,
    PH_LEN_LO = 4'd6,
    PH_LEN_HI = 4'd7,
    PH_DATA   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_FRAME_GOOD = 3'd1,
    KIND_CRC_FAILED = 3'd2,
    KIND_BAD_LENGTH = 3'd3,
    KIND_OVERFLOW   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_offset;
    logic [15:0] block_word;
    logic [15:0] frame_length;
    logic [31:0] crc_fail_count;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] pb,
                                          input logic [7:0] off, input logic [15:0] id,
                                          input logic [15:0] len, input logic [31:0] errs,
                                          input logic lst);
    result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.byte_offset    = off;
    r.block_word     = id;
    r.frame_length   = len;
    r.crc_fail_count = errs;
    r.last           = lst;
    return r;
  endfunction

endpackage

>>> rtl/sbf_block_deframer_crc16.sv
// Each result is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall is low; the CRC update is a single bytewise step.
// A frame's final payload byte causes two results, which are pushed together into a
// four-entry result queue; input stalls while fewer than two entries are free.
// Reset (rst, synchronous, active high) empties the queue, returns to the preamble hunt,
// clears all frame state and the failure counter, and loads sync bytes 36 and 64.
module sbf_block_deframer_crc16 import sbfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [7:0]           payload_byte,
  output logic [7:0]           byte_offset,
  output logic [15:0]          block_word,
  output logic [15:0]          frame_length,
  output logic [31:0]          crc_fail_count,
  output logic                 last
);

  localparam logic [15:0] MAX_P = 16'(MAX_PAYLOAD);

  logic [7:0]  first_sync;
  logic [7:0]  second_sync;
  phase_t      phase, phase_next;
  logic [15:0] received_crc, received_crc_next;
  logic [15:0] block_id_reg, block_id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [31:0] crc_errors, crc_errors_next;

  logic [1:0]  res_n;
  result_t     res0, res1;

  result_t     queue [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  cnt;
  logic        in_fire;
  logic        out_fire;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;
  assign in_stall  = (cnt > 3'd2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (cnt != 3'd0);
  assign out_fire  = out_valid && !out_stall;
  assign push_n    = in_fire ? res_n : 2'd0;

  always_comb begin
    logic [15:0] crc_new;
    logic [15:0] len_new;
    logic [15:0] count_new;
    kind_t       fin_kind;
    logic [31:0] errs_new;
    phase_next         = phase;
    received_crc_next  = received_crc;
    block_id_reg_next  = block_id_reg;
    length_reg_next    = length_reg;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    crc_errors_next    = crc_errors;
    res_n              = 2'd0;
    res0               = '0;
    res1               = '0;
    crc_new            = crc_byte(running_crc, rx_byte);
    len_new            = {rx_byte, length_reg[7:0]};
    count_new          = payload_count + 16'd1;
    fin_kind           = (crc_new == received_crc) ? KIND_FRAME_GOOD : KIND_CRC_FAILED;
    errs_new           = (crc_new == received_crc) ? crc_errors : crc_errors + 32'd1;
    unique case (phase)
      PH_SYNC2: begin
        phase_next = (rx_byte == second_sync) ? PH_CRC_LO : PH_SYNC1;
      end
      PH_CRC_LO: begin
        received_crc_next = {8'h00, rx_byte};
        phase_next        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        received_crc_next = {rx_byte, received_crc[7:0]};
        running_crc_next  = '0;
        phase_next        = PH_ID_LO;
      end
      PH_ID_LO: begin
        block_id_reg_next = {8'h00, rx_byte};
        running_crc_next  = crc_new;
        phase_next        = PH_ID_HI;
      end
      PH_ID_HI: begin
        block_id_reg_next = {rx_byte, block_id_reg[7:0]};
        running_crc_next  = crc_new;
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next  = {8'h00, rx_byte};
        running_crc_next = crc_new;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_reg_next  = len_new;
        running_crc_next = crc_new;
        if (len_new[1:0] != 2'd0 || len_new < HEADER_LEN) begin
          phase_next = PH_SYNC1;
          res_n      = 2'd1;
          res0       = make_result(KIND_BAD_LENGTH, 8'd0, 8'd0, block_id_reg, len_new,
                                   crc_errors, 1'b1);
        end else if (len_new == HEADER_LEN) begin
          phase_next      = PH_SYNC1;
          crc_errors_next = errs_new;
          res_n           = 2'd1;
          res0            = make_result(fin_kind, 8'd0, 8'd0, block_id_reg, len_new,
                                        errs_new, 1'b1);
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (payload_count >= MAX_P) begin
          phase_next = PH_SYNC1;
          res_n      = 2'd1;
          res0       = make_result(KIND_OVERFLOW, 8'd0, 8'd0, block_id_reg, length_reg,
                                   crc_errors, 1'b1);
        end else begin
          running_crc_next   = crc_new;
          payload_count_next = count_new;
          res0 = make_result(KIND_PAYLOAD, rx_byte, payload_count[7:0], block_id_reg,
                             length_reg, crc_errors, 1'b1);
          if (count_new >= length_reg - HEADER_LEN) begin
            phase_next      = PH_SYNC1;
            crc_errors_next = errs_new;
            res_n           = 2'd2;
            res0.last       = 1'b0;
            res1 = make_result(fin_kind, 8'd0, 8'd0, block_id_reg, length_reg,
                               errs_new, 1'b1);
          end else begin
            res_n = 2'd1;
          end
        end
      end
      default: begin
        if (rx_byte == first_sync) begin
          phase_next         = PH_SYNC2;
          payload_count_next = '0;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync    <= FIRST_SYNC_RESET;
      second_sync   <= SECOND_SYNC_RESET;
      phase         <= PH_SYNC1;
      received_crc  <= '0;
      block_id_reg  <= '0;
      length_reg    <= '0;
      payload_count <= '0;
      running_crc   <= '0;
      crc_errors    <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      cnt           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_SYNC) begin
          first_sync <= cfg_data;
        end else if (cfg_index == CFG_SECOND_SYNC) begin
          second_sync <= cfg_data;
        end
      end
      if (in_fire) begin
        phase         <= phase_next;
        received_crc  <= received_crc_next;
        block_id_reg  <= block_id_reg_next;
        length_reg    <= length_reg_next;
        payload_count <= payload_count_next;
        running_crc   <= running_crc_next;
        crc_errors    <= crc_errors_next;
      end
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, out_fire};
      cnt    <= cnt + {1'b0, push_n} - {2'b00, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  assign kind           = queue[rd_ptr].kind;
  assign payload_byte   = queue[rd_ptr].payload_byte;
  assign byte_offset    = queue[rd_ptr].byte_offset;
  assign block_word     = queue[rd_ptr].block_word;
  assign frame_length   = queue[rd_ptr].frame_length;
  assign crc_fail_count = queue[rd_ptr].crc_fail_count;
  assign last           = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue holds more than four transactions");

  a_hunt_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_SYNC1) |=> cnt <= $past(cnt))
    else $error("a preamble hunt byte produced a result");

  a_inner_is_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> kind == KIND_PAYLOAD)
    else $error("a non-final result is not a payload byte");

endmodule

>>> verif/tb.sv
module tb import sbfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD   = 256;
  localparam int PERIOD        = 4;
  localparam int RANDOM_ITEMS  = 300;
  localparam int RETUNE_EVERY  = 100;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LIMIT_NS      = 4_000_000;

  class deframe_tracker;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    phase_t      ph;
    logic [15:0] crc_rx;
    logic [15:0] crc_run;
    logic [15:0] id_word;
    logic [15:0] len_word;
    logic [15:0] taken;
    logic [31:0] fail_total;
    int unsigned payload_limit;
    int          mismatches;
    result_t     results_due[$];

    function new(input int unsigned limit);
      payload_limit = limit;
      sync_a = FIRST_SYNC_RESET;
      sync_b = SECOND_SYNC_RESET;
      ph = PH_SYNC1;
      crc_rx = '0;
      crc_run = '0;
      id_word = '0;
      len_word = '0;
      taken = '0;
      fail_total = '0;
      mismatches = 0;
    endfunction

    static function logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r = {r[14:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    function void set_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
      if (idx == CFG_FIRST_SYNC) begin
        sync_a = val;
      end else if (idx == CFG_SECOND_SYNC) begin
        sync_b = val;
      end
    endfunction

    function void emit(input kind_t k, input logic [7:0] pb, input logic [7:0] off);
      result_t r;
      r.kind           = k;
      r.payload_byte   = pb;
      r.byte_offset    = off;
      r.block_word     = id_word;
      r.frame_length   = len_word;
      r.crc_fail_count = fail_total;
      r.last           = 1'b0;
      results_due.push_back(r);
    endfunction

    function void close_frame();
      kind_t k;
      k = KIND_FRAME_GOOD;
      if (crc_run != crc_rx) begin
        fail_total = fail_total + 32'd1;
        k = KIND_CRC_FAILED;
      end
      ph = PH_SYNC1;
      emit(k, 8'h00, 8'h00);
    endfunction

    function void take_byte(input logic [7:0] b);
      int prior;
      prior = results_due.size();
      case (ph)
        PH_SYNC2: begin
          ph = (b == sync_b) ? PH_CRC_LO : PH_SYNC1;
        end
        PH_CRC_LO: begin
          crc_rx = {8'h00, b};
          ph = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_rx[15:8] = b;
          crc_run = '0;
          ph = PH_ID_LO;
        end
        PH_ID_LO: begin
          id_word = {8'h00, b};
          crc_run = ccitt_step(crc_run, b);
          ph = PH_ID_HI;
        end
        PH_ID_HI: begin
          id_word[15:8] = b;
          crc_run = ccitt_step(crc_run, b);
          ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_word = {8'h00, b};
          crc_run = ccitt_step(crc_run, b);
          ph = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_word[15:8] = b;
          crc_run = ccitt_step(crc_run, b);
          if (len_word[1:0] != 2'b00 || len_word < HEADER_LEN) begin
            ph = PH_SYNC1;
            emit(KIND_BAD_LENGTH, 8'h00, 8'h00);
          end else if (len_word == HEADER_LEN) begin
            close_frame();
          end else begin
            ph = PH_DATA;
          end
        end
        PH_DATA: begin
          if (taken >= payload_limit) begin
            ph = PH_SYNC1;
            emit(KIND_OVERFLOW, 8'h00, 8'h00);
          end else begin
            emit(KIND_PAYLOAD, b, taken[7:0]);
            crc_run = ccitt_step(crc_run, b);
            taken = taken + 16'd1;
            if (taken >= len_word - HEADER_LEN) begin
              close_frame();
            end
          end
        end
        default: begin
          if (b == sync_a) begin
            ph = PH_SYNC2;
            taken = '0;
          end else begin
            ph = PH_SYNC1;
          end
        end
      endcase
      if (results_due.size() > prior) begin
        results_due[results_due.size() - 1].last = 1'b1;
      end
    endfunction

    task report(input string msg);
      $display("%t  mismatch  %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s: got 'h%0h, want 'h%0h", name, got, want));
      end
    endtask

    task check_result(input result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with nothing outstanding, kind %0d", got.kind));
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("byte_offset", got.byte_offset, want.byte_offset);
      compare_field("block_word", got.block_word, want.block_word);
      compare_field("frame_length", got.frame_length, want.frame_length);
      compare_field("crc_fail_count", got.crc_fail_count, want.crc_fail_count);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           kind;
  logic [7:0]           payload_byte;
  logic [7:0]           byte_offset;
  logic [15:0]          block_word;
  logic [15:0]          frame_length;
  logic [31:0]          crc_fail_count;
  logic                 last;

  deframe_tracker frames;
  result_t        seen;
  int             hold_requests = 0;
  bit             steady = 1'b0;

  sbf_block_deframer_crc16 #(.MAX_PAYLOAD(MAX_PAYLOAD)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .byte_offset    (byte_offset),
    .block_word     (block_word),
    .frame_length   (frame_length),
    .crc_fail_count (crc_fail_count),
    .last           (last)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        frames.take_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        seen.kind           = kind_t'(kind);
        seen.payload_byte   = payload_byte;
        seen.byte_offset    = byte_offset;
        seen.block_word     = block_word;
        seen.frame_length   = frame_length;
        seen.crc_fail_count = crc_fail_count;
        seen.last           = last;
        frames.check_result(seen);
      end
    end
  end

  initial begin : result_sink
    int span;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 14) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(60, 150)) @(posedge clk);
      end else begin
        span = idle_span();
        out_stall <= (span != 0);
        repeat (span) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int g;
    g = steady ? 0 : idle_span();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input int body,
                            input bit spoil);
    logic [7:0]  data[];
    logic [15:0] crc;
    data = new[body];
    crc = '0;
    crc = deframe_tracker::ccitt_step(crc, id[7:0]);
    crc = deframe_tracker::ccitt_step(crc, id[15:8]);
    crc = deframe_tracker::ccitt_step(crc, len[7:0]);
    crc = deframe_tracker::ccitt_step(crc, len[15:8]);
    for (int i = 0; i < body; i++) begin
      data[i] = 8'($urandom);
      crc = deframe_tracker::ccitt_step(crc, data[i]);
    end
    if (spoil) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    send_byte(frames.sync_a);
    send_byte(frames.sync_b);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    send_byte(id[7:0]);
    send_byte(id[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < body; i++) begin
      send_byte(data[i]);
    end
  endtask

  task automatic settle(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames.results_due.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frames.results_due.size() != 0) begin
      frames.report($sformatf("%0d results never arrived", frames.results_due.size()));
    end
  endtask

  task automatic write_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames.set_sync(idx, val);
    @(posedge clk);
  endtask

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          sent;
    int          next_retune;
    int          pick;
    int          body;
    int          nb;
    bit          pressed;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  v;

    frames = new(MAX_PAYLOAD);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_sync(CFG_FIRST_SYNC, FIRST_SYNC_RESET);
    write_sync(CFG_SECOND_SYNC, SECOND_SYNC_RESET);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(frames.sync_a);
    send_byte(frames.sync_a);
    send_byte(frames.sync_b);
    send_frame(16'h0000, 16'd8, 0, 1'b0);
    send_frame(16'hFFFF, 16'd8, 0, 1'b1);
    send_frame(16'h5A5A, 16'd5, 0, 1'b0);
    send_frame(16'hA5A5, 16'd4, 0, 1'b0);
    send_frame(16'h0001, 16'd0, 0, 1'b0);
    send_frame(16'h8000, 16'hFFFF, 0, 1'b0);
    send_frame(16'h1234, 16'd10, 0, 1'b0);
    send_frame(16'h4321, 16'd12, 4, 1'b0);
    send_frame(16'hBEEF, 16'd12, 4, 1'b1);
    hold_requests <= hold_requests + 1;
    send_frame(16'hC0DE, 16'd8 + 16'(MAX_PAYLOAD), MAX_PAYLOAD, 1'b0);
    send_frame(16'h7FFF, 16'hFFFC, MAX_PAYLOAD + 1, 1'b0);

    settle(DRAIN_LIMIT);
    write_sync(CFG_FIRST_SYNC, 8'h00);
    write_sync(CFG_SECOND_SYNC, 8'hFF);
    send_frame(16'h0F0F, 16'd16, 8, 1'b0);
    settle(DRAIN_LIMIT);
    write_sync(CFG_FIRST_SYNC, 8'hFF);
    write_sync(CFG_SECOND_SYNC, 8'h00);
    send_frame(16'hF0F0, 16'd16, 8, 1'b1);
    settle(DRAIN_LIMIT);
    write_sync(CFG_FIRST_SYNC, 8'h7E);
    write_sync(CFG_SECOND_SYNC, 8'h7E);
    send_frame(16'h2468, 16'd20, 12, 1'b0);
    settle(DRAIN_LIMIT);

    sent = 0;
    next_retune = 0;
    pressed = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_retune) begin
        settle(DRAIN_LIMIT);
        case ($urandom_range(0, 4))
          0: begin
            write_sync(CFG_FIRST_SYNC, 8'h00);
            write_sync(CFG_SECOND_SYNC, 8'hFF);
          end
          1: begin
            write_sync(CFG_SECOND_SYNC, 8'h00);
            write_sync(CFG_FIRST_SYNC, 8'hFF);
          end
          2: begin
            v = 8'($urandom);
            write_sync(CFG_FIRST_SYNC, v);
            write_sync(CFG_SECOND_SYNC, v);
          end
          3: begin
            write_sync(CFG_FIRST_SYNC, FIRST_SYNC_RESET);
            write_sync(CFG_SECOND_SYNC, SECOND_SYNC_RESET);
          end
          default: begin
            write_sync(CFG_FIRST_SYNC, 8'($urandom));
            write_sync(CFG_SECOND_SYNC, 8'($urandom));
          end
        endcase
        next_retune += RETUNE_EVERY;
      end
      if (!pressed && sent >= 150) begin
        hold_requests <= hold_requests + 1;
        pressed = 1'b1;
      end
      steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      id = 16'($urandom);
      if (pick < 62) begin
        len = 16'd8 + 16'(4 * $urandom_range(0, 12));
        body = int'(len) - 8;
        send_frame(id, len, body, $urandom_range(0, 3) == 0);
        sent += 8 + body;
      end else if (pick < 65) begin
        len = 16'd8 + 16'(4 * $urandom_range(13, MAX_PAYLOAD / 4));
        body = int'(len) - 8;
        send_frame(id, len, body, $urandom_range(0, 3) == 0);
        sent += 8 + body;
      end else if (pick < 66) begin
        len = 16'd268 + 16'(4 * $urandom_range(0, 16316));
        send_frame(id, len, MAX_PAYLOAD + 1, 1'b0);
        sent += 8 + MAX_PAYLOAD + 1;
      end else if (pick < 78) begin
        if ($urandom_range(0, 2) == 0) begin
          len = 16'($urandom_range(0, 7));
        end else begin
          len = 16'($urandom);
          if (len[1:0] == 2'b00) begin
            len[1:0] = 2'($urandom_range(1, 3));
          end
        end
        send_frame(id, len, 0, 1'b0);
        sent += 8;
      end else if (pick < 90) begin
        len = 16'd8 + 16'(4 * $urandom_range(1, 8));
        body = $urandom_range(0, int'(len) - 9);
        send_frame(id, len, body, $urandom_range(0, 1) == 0);
        sent += 8 + body;
      end else begin
        nb = $urandom_range(1, 6);
        repeat (nb) send_byte(8'($urandom));
        sent += nb;
      end
    end
    steady = 1'b0;

    settle(DRAIN_LIMIT);
    if (frames.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
